// ===== hw/rtl/fdcp_pkg.sv =====
// shared types and constants of the framed display command parser
// used by fdcp_ctrl, fdcp_dp and framed_display_command_parser; no dependencies
`timescale 1ns / 1ps

package fdcp_pkg;

  // framing bytes and command codes
  localparam logic [7:0] BYTE_STX     = 8'h02;
  localparam logic [7:0] BYTE_ETX     = 8'h03;
  localparam logic [7:0] OP_PRINT     = 8'h04;
  localparam logic [7:0] OP_CLEARLINE = 8'h05;
  localparam logic [7:0] OP_CLEARDISP = 8'h06;
  localparam logic [7:0] OP_SETGLYPH  = 8'h07;
  localparam logic [7:0] OP_ON        = 8'h08;
  localparam logic [7:0] OP_OFF       = 8'h09;

  // character code classes
  localparam logic [7:0] CODE_FONT_LO = 8'h20;
  localparam logic [7:0] CODE_DEL     = 8'h7F;

  // result kinds
  localparam logic [1:0] EV_CLEAR = 2'd0;
  localparam logic [1:0] EV_ON    = 2'd1;
  localparam logic [1:0] EV_OFF   = 2'd2;
  localparam logic [1:0] EV_GLYPH = 2'd3;

  // fixed geometry
  localparam int CHARS_PER_LINE = 32;
  localparam int CHAR_PITCH     = 6;
  localparam int GLYPH_ROWS     = 8;
  localparam int MAX_OUT        = 32;
  localparam int ROWS_W         = GLYPH_ROWS * 8;
  localparam int ROW_CNT_W      = $clog2(GLYPH_ROWS + 1);
  localparam int RUN_W          = $clog2(MAX_OUT + 1);

  // frame parser phase
  typedef enum logic [3:0] {
    PH_WAIT  = 4'b0001,
    PH_CMD   = 4'b0010,
    PH_PARAM = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

  // sequencer state
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SC_ADDR = 6'b000010,
    S_SC_BYTE = 6'b000100,
    S_SC_PUT  = 6'b001000,
    S_FLUSH   = 6'b010000,
    S_GLY     = 6'b100000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic take_cmd;
    logic take_param;
    logic take_data;
    logic take_end;
    logic load_event;
    logic scan_init;
    logic scan_latch;
    logic scan_next;
    logic scan_put;
    logic flush;
    logic gly_init;
    logic gly_step;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_stx;
    logic is_etx;
    logic is_param_op;
    logic is_event_op;
    logic cmd_print;
    logic cmd_setglyph;
    logic cmd_clearline;
    logic fill_last;
    logic scan_end;
    logic byte_zero;
    logic byte_high;
    logic out_free;
    logic cand_valid;
    logic gly_done;
    logic param_ok;
  } dp_sts_t;

endpackage

// ===== hw/rtl/fdcp_ctrl.sv =====
// controller of the framed display command parser: frame phase and sequencer
// depends on fdcp_pkg
`timescale 1ns / 1ps

module fdcp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fdcp_pkg::dp_sts_t sts,
  output fdcp_pkg::dp_ctl_t ctl
);

  fdcp_pkg::state_t state, state_next;
  fdcp_pkg::phase_t phase, phase_next;
  logic             acc;

  // bytes are taken only while the sequencer is idle
  assign in_ready = (state == fdcp_pkg::S_IDLE);
  assign acc      = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    ctl        = '0;
    unique case (state)
      fdcp_pkg::S_IDLE: begin
        if (acc) begin
          unique case (phase)
            fdcp_pkg::PH_WAIT: begin
              if (sts.is_stx) begin
                ctl.start  = 1'b1;
                phase_next = fdcp_pkg::PH_CMD;
              end
            end
            fdcp_pkg::PH_CMD: begin
              ctl.take_cmd = 1'b1;
              phase_next   = sts.is_param_op ? fdcp_pkg::PH_PARAM : fdcp_pkg::PH_WAIT;
              if (sts.is_event_op) begin
                ctl.load_event = 1'b1;
                state_next     = fdcp_pkg::S_FLUSH;
              end
            end
            fdcp_pkg::PH_PARAM: begin
              ctl.take_param = 1'b1;
              phase_next     = sts.cmd_clearline ? fdcp_pkg::PH_WAIT : fdcp_pkg::PH_DATA;
            end
            fdcp_pkg::PH_DATA: begin
              if (sts.is_etx) begin
                ctl.take_end = 1'b1;
                phase_next   = fdcp_pkg::PH_WAIT;
                if (sts.cmd_print) begin
                  ctl.scan_init = 1'b1;
                  state_next    = fdcp_pkg::S_SC_ADDR;
                end else if (sts.cmd_setglyph && sts.param_ok) begin
                  ctl.gly_init = 1'b1;
                  state_next   = fdcp_pkg::S_GLY;
                end
              end else begin
                ctl.take_data = 1'b1;
                if (sts.fill_last) begin
                  phase_next = fdcp_pkg::PH_WAIT;
                end
              end
            end
            default: phase_next = fdcp_pkg::PH_WAIT;
          endcase
        end
      end
      // store address for the current slot is presented
      fdcp_pkg::S_SC_ADDR: begin
        if (sts.scan_end) begin
          state_next = sts.cand_valid ? fdcp_pkg::S_FLUSH : fdcp_pkg::S_IDLE;
        end else begin
          state_next = fdcp_pkg::S_SC_BYTE;
        end
      end
      // stored character is available
      fdcp_pkg::S_SC_BYTE: begin
        if (sts.byte_zero) begin
          state_next = sts.cand_valid ? fdcp_pkg::S_FLUSH : fdcp_pkg::S_IDLE;
        end else begin
          ctl.scan_latch = 1'b1;
          if (sts.byte_high) begin
            ctl.scan_next = 1'b1;
            state_next    = fdcp_pkg::S_SC_ADDR;
          end else begin
            state_next = fdcp_pkg::S_SC_PUT;
          end
        end
      end
      // older placement moves out, new one becomes pending
      fdcp_pkg::S_SC_PUT: begin
        if (!sts.cand_valid || sts.out_free) begin
          ctl.scan_put  = 1'b1;
          ctl.scan_next = 1'b1;
          state_next    = fdcp_pkg::S_SC_ADDR;
        end
      end
      // last pending result of the command goes out
      fdcp_pkg::S_FLUSH: begin
        if (sts.out_free) begin
          ctl.flush  = 1'b1;
          state_next = fdcp_pkg::S_IDLE;
        end
      end
      // gather eight stored bytes into a custom bitmap
      fdcp_pkg::S_GLY: begin
        ctl.gly_step = 1'b1;
        if (sts.gly_done) begin
          state_next = fdcp_pkg::S_IDLE;
        end
      end
      default: state_next = fdcp_pkg::S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdcp_pkg::S_IDLE;
      phase <= fdcp_pkg::PH_WAIT;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== hw/rtl/fdcp_dp.sv =====
// datapath of the framed display command parser: frame registers, line store,
// custom glyph store, scan counters, pending and output result registers
// depends on fdcp_pkg
`timescale 1ns / 1ps

module fdcp_dp #(
  parameter int TEXT_BYTES   = 64,
  parameter int CUSTOM_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  rx_byte,
  input  fdcp_pkg::dp_ctl_t           ctl,
  output fdcp_pkg::dp_sts_t           sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  event_kind,
  output logic [7:0]                  pixel_x,
  output logic [7:0]                  pixel_y,
  output logic                        glyph_custom,
  output logic [6:0]                  glyph_code,
  output logic [fdcp_pkg::ROWS_W-1:0] glyph_rows,
  output logic                        last_in_run
);

  localparam int SIDX_W     = $clog2(TEXT_BYTES);
  localparam int FILL_W     = SIDX_W + 1;
  localparam int SCAN_LIMIT = (fdcp_pkg::CHARS_PER_LINE < TEXT_BYTES) ?
                              fdcp_pkg::CHARS_PER_LINE : TEXT_BYTES;
  localparam int GIDX_W     = (CUSTOM_COUNT > 1) ? $clog2(CUSTOM_COUNT) : 1;
  localparam int RW         = fdcp_pkg::ROWS_W;

  // frame registers
  logic [7:0]        frame_command;
  logic [7:0]        frame_param;
  logic [FILL_W-1:0] fill_count;

  // line store
  logic [7:0]            text_mem [TEXT_BYTES];
  logic [TEXT_BYTES-1:0] text_vld;
  logic [7:0]            rd_q;
  logic                  rd_vq;
  logic [SIDX_W-1:0]     rd_addr;
  logic [SIDX_W-1:0]     wr_addr;
  logic [7:0]            wr_data;
  logic                  wr_en;
  logic [7:0]            scan_byte;

  // custom glyph store
  logic [RW-1:0]           glyph_mem [CUSTOM_COUNT];
  logic [CUSTOM_COUNT-1:0] glyph_vld;
  logic [RW-1:0]           g_q;
  logic                    g_vq;
  logic [4:0]              g_addr;
  logic                    g_in_range;
  logic                    gw_en;
  logic [RW-1:0]           gw_data;

  // scan and gather
  logic [FILL_W-1:0]              scan_idx;
  logic [7:0]                     x_acc;
  logic [fdcp_pkg::RUN_W-1:0]     run_cnt;
  logic [6:0]                     cur_code;
  logic                           cur_custom;
  logic [fdcp_pkg::ROW_CNT_W-1:0] row_cnt;
  logic [RW-1:0]                  row_acc;
  logic [7:0]                     line_y;

  // pending result
  logic          cand_valid;
  logic [1:0]    cand_kind;
  logic [7:0]    cand_x;
  logic [7:0]    cand_y;
  logic          cand_custom;
  logic [6:0]    cand_code;
  logic [RW-1:0] cand_rows;
  logic [1:0]    ev_kind;
  logic          out_free;
  logic          load_out;

  // store addressing
  assign scan_byte = rd_vq ? rd_q : 8'h00;
  assign rd_addr   = ctl.gly_step ? SIDX_W'(row_cnt) : scan_idx[SIDX_W-1:0];
  assign wr_addr   = fill_count[SIDX_W-1:0];
  assign wr_en     = ctl.take_data || ctl.take_end;
  assign wr_data   = ctl.take_end ? 8'h00 : rx_byte;

  assign g_addr     = scan_byte[4:0];
  assign g_in_range = {1'b0, g_addr} < 6'(CUSTOM_COUNT);
  assign gw_en      = ctl.gly_step && sts.gly_done && sts.param_ok;
  assign gw_data    = {scan_byte, row_acc[RW-1:8]};

  // top row of the line, wraps at eight bits
  assign line_y = {frame_param[4:0] - 5'd1, 3'b000};

  assign out_free = !out_valid || out_ready;
  assign load_out = (ctl.scan_put && cand_valid) || ctl.flush;

  // event kind of a command byte
  always_comb begin
    unique case (rx_byte)
      fdcp_pkg::OP_CLEARDISP: ev_kind = fdcp_pkg::EV_CLEAR;
      fdcp_pkg::OP_ON:        ev_kind = fdcp_pkg::EV_ON;
      default:                ev_kind = fdcp_pkg::EV_OFF;
    endcase
  end

  // status to the controller
  always_comb begin
    sts.is_stx        = (rx_byte == fdcp_pkg::BYTE_STX);
    sts.is_etx        = (rx_byte == fdcp_pkg::BYTE_ETX);
    sts.is_param_op   = (rx_byte == fdcp_pkg::OP_PRINT) ||
                        (rx_byte == fdcp_pkg::OP_CLEARLINE) ||
                        (rx_byte == fdcp_pkg::OP_SETGLYPH);
    sts.is_event_op   = (rx_byte == fdcp_pkg::OP_CLEARDISP) ||
                        (rx_byte == fdcp_pkg::OP_ON) ||
                        (rx_byte == fdcp_pkg::OP_OFF);
    sts.cmd_print     = (frame_command == fdcp_pkg::OP_PRINT);
    sts.cmd_setglyph  = (frame_command == fdcp_pkg::OP_SETGLYPH);
    sts.cmd_clearline = (frame_command == fdcp_pkg::OP_CLEARLINE);
    sts.fill_last     = (fill_count == FILL_W'(TEXT_BYTES - 1));
    sts.scan_end      = (scan_idx >= FILL_W'(SCAN_LIMIT)) ||
                        (run_cnt == fdcp_pkg::RUN_W'(fdcp_pkg::MAX_OUT));
    sts.byte_zero     = (scan_byte == 8'h00);
    sts.byte_high     = (scan_byte >= fdcp_pkg::CODE_DEL);
    sts.out_free      = out_free;
    sts.cand_valid    = cand_valid;
    sts.gly_done      = (row_cnt == fdcp_pkg::ROW_CNT_W'(fdcp_pkg::GLYPH_ROWS));
    sts.param_ok      = (frame_param < 8'(CUSTOM_COUNT));
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_command <= 8'h00;
      frame_param   <= 8'h00;
      fill_count    <= '0;
    end else begin
      if (ctl.start) begin
        frame_command <= 8'h00;
        frame_param   <= 8'h00;
        fill_count    <= '0;
      end
      if (ctl.take_cmd) begin
        frame_command <= rx_byte;
      end
      if (ctl.take_param) begin
        frame_param <= rx_byte;
      end
      if (ctl.take_data) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // line store memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_mem[wr_addr] <= wr_data;
    end
    rd_q <= text_mem[rd_addr];
  end

  // line store valid bits, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      text_vld <= '0;
      rd_vq    <= 1'b0;
    end else begin
      if (wr_en) begin
        text_vld[wr_addr] <= 1'b1;
      end
      rd_vq <= text_vld[rd_addr];
    end
  end

  // custom glyph memory, registered read
  always_ff @(posedge clk) begin
    if (gw_en) begin
      glyph_mem[frame_param[GIDX_W-1:0]] <= gw_data;
    end
    if (ctl.scan_latch && g_in_range) begin
      g_q <= glyph_mem[g_addr[GIDX_W-1:0]];
    end
  end

  // custom glyph valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_vld <= '0;
      g_vq      <= 1'b0;
    end else begin
      if (gw_en) begin
        glyph_vld[frame_param[GIDX_W-1:0]] <= 1'b1;
      end
      if (ctl.scan_latch) begin
        g_vq <= g_in_range && glyph_vld[g_addr[GIDX_W-1:0]];
      end
    end
  end

  // scan counters and current character
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      x_acc    <= 8'h00;
      run_cnt  <= '0;
    end else begin
      if (ctl.scan_init) begin
        scan_idx <= '0;
        x_acc    <= 8'h00;
        run_cnt  <= '0;
      end
      if (ctl.scan_next) begin
        scan_idx <= scan_idx + FILL_W'(1);
        x_acc    <= x_acc + 8'(fdcp_pkg::CHAR_PITCH);
      end
      if (ctl.scan_put) begin
        run_cnt <= run_cnt + fdcp_pkg::RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_latch) begin
      cur_code   <= scan_byte[6:0];
      cur_custom <= (scan_byte < fdcp_pkg::CODE_FONT_LO);
    end
  end

  // bitmap gather, row zero ends in the low byte
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (ctl.gly_init) begin
      row_cnt <= '0;
    end else if (ctl.gly_step) begin
      row_cnt <= row_cnt + fdcp_pkg::ROW_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.gly_init) begin
      row_acc <= '0;
    end else if (ctl.gly_step && (row_cnt != '0)) begin
      row_acc <= {scan_byte, row_acc[RW-1:8]};
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (ctl.load_event || ctl.scan_put) begin
      cand_valid <= 1'b1;
    end else if (ctl.flush) begin
      cand_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_event) begin
      cand_kind   <= ev_kind;
      cand_x      <= 8'h00;
      cand_y      <= 8'h00;
      cand_custom <= 1'b0;
      cand_code   <= 7'h00;
      cand_rows   <= '0;
    end else if (ctl.scan_put) begin
      cand_kind   <= fdcp_pkg::EV_GLYPH;
      cand_x      <= x_acc;
      cand_y      <= line_y;
      cand_custom <= cur_custom;
      cand_code   <= cur_code;
      cand_rows   <= (cur_custom && g_vq) ? g_q : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      event_kind   <= cand_kind;
      pixel_x      <= cand_x;
      pixel_y      <= cand_y;
      glyph_custom <= cand_custom;
      glyph_code   <= cand_code;
      glyph_rows   <= cand_rows;
      last_in_run  <= ctl.flush;
    end
  end

endmodule

// ===== hw/rtl/framed_display_command_parser.sv =====
// framed display command parser: a byte is taken whenever the sequencer is idle
// a clear, on or off command loads the pending result, then the output register once free
// print line reads the line store per slot: address and byte states, a put state if drawn
// set glyph gathers one stored byte per cycle from the same read port
// reset is synchronous: parser waits for a start byte, line and glyph stores read as zero
// depends on fdcp_pkg, fdcp_ctrl, fdcp_dp
`timescale 1ns / 1ps

module framed_display_command_parser #(
  parameter int TEXT_BYTES   = 64,
  parameter int CUSTOM_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  event_kind,
  output logic [7:0]                  pixel_x,
  output logic [7:0]                  pixel_y,
  output logic                        glyph_custom,
  output logic [6:0]                  glyph_code,
  output logic [fdcp_pkg::ROWS_W-1:0] glyph_rows,
  output logic                        last_in_run
);

  fdcp_pkg::dp_ctl_t ctl;
  fdcp_pkg::dp_sts_t sts;

  // controller
  fdcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  fdcp_dp #(
    .TEXT_BYTES   (TEXT_BYTES),
    .CUSTOM_COUNT (CUSTOM_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .ctl          (ctl),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .event_kind   (event_kind),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .glyph_custom (glyph_custom),
    .glyph_code   (glyph_code),
    .glyph_rows   (glyph_rows),
    .last_in_run  (last_in_run)
  );

  // no pending result is left behind once the sequencer is idle
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.cand_valid)
    else $error("pending result left while idle");

  // display events are single items with blank placement fields
  a_event_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != fdcp_pkg::EV_GLYPH) |->
      last_in_run && (pixel_x == 8'h00) && (glyph_code == 7'h00) && !glyph_custom)
    else $error("display event with placement fields");

  // font glyphs carry no bitmap
  a_font_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !glyph_custom |-> (glyph_rows == '0))
    else $error("font glyph with bitmap rows");

  // a byte is never taken while a result is loaded in the same cycle
  a_no_take_on_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(ctl.flush || ctl.scan_put))
    else $error("byte taken during result transfer");

endmodule
